// ===== hw/rtl/pfpt_pkg.sv =====
`default_nettype none
package pfpt_pkg;
    localparam int MAX_VERTICES_DEF  = 16;
    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 1024;
    localparam int LAYERS_DEF        = 4;
    localparam int MIN_POLY_VERTICES = 3;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_TEST   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic REG_FILL_COLOR   = 1'b0;
    localparam logic REG_TARGET_LAYER = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch the item, reset edge walk
        logic append;    // write vertex at count
        logic clear;     // zero the count
        logic rd_first;  // read last vertex as j
        logic rd_next;   // read vertex i
        logic edge_go;   // evaluate edge, start divider if needed
        logic div_step;  // one divider step
        logic div_done;  // finish crossing compare
        logic adv;       // advance edge index
        logic finish;    // build result
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       empty;
        logic       last_edge;
        logic       need_div;
        logic       div_last;
    } t_sts;
endpackage
`default_nettype wire

// ===== hw/rtl/polygon_fill_pixel_test_core.sv =====
`default_nettype none
// Even-odd polygon fill test. Each item (clear, append vertex, test pixel) is
// taken when start is high and busy low, and yields one result held for a
// single cycle with o_done; the receiver cannot stall, so it must take it then.
// o_done comes in the first cycle after busy falls. Clear, append and a test of
// an empty table only pass through decode and finish. A test reads the last
// vertex, then walks every edge, and each edge that crosses the pixel row runs
// a 25-step serial divider shared by all edges before its crossing compare.
module polygon_fill_pixel_test_core
    import pfpt_pkg::*;
#(
    parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int LAYERS        = LAYERS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_cmd,
    input  wire logic signed [11:0] i_coord_x,
    input  wire logic signed [11:0] i_coord_y,
    output logic                    o_done,
    output logic [1:0]              o_status,
    output logic                    o_inside_res,
    output logic                    o_write_enable,
    output logic [23:0]             o_write_color,
    output logic [1:0]              o_write_layer,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data
);
    t_ctl w_ctl;
    t_sts w_sts;
    logic [23:0] r_fill_color;
    logic [1:0]  r_target_layer;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_color <= '0;
            r_target_layer <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FILL_COLOR:   r_fill_color <= i_cfg_data;
                REG_TARGET_LAYER: r_target_layer <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    pfpt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .o_done(o_done), .o_ctl(w_ctl), .i_sts(w_sts)
    );

    pfpt_datapath #(
        .MAX_VERTICES(MAX_VERTICES), .SCREEN_WIDTH(SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT), .LAYERS(LAYERS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .o_sts(w_sts),
        .i_cmd(i_cmd), .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .i_fill_color(r_fill_color), .i_target_layer(r_target_layer),
        .o_status(o_status), .o_inside_res(o_inside_res),
        .o_write_enable(o_write_enable), .o_write_color(o_write_color),
        .o_write_layer(o_write_layer)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/pfpt_datapath.sv =====
`default_nettype none
module pfpt_datapath
    import pfpt_pkg::*;
#(
    parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int LAYERS        = LAYERS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_ctl               i_ctl,
    output t_sts                    o_sts,
    input  wire logic [1:0]         i_cmd,
    input  wire logic signed [11:0] i_coord_x,
    input  wire logic signed [11:0] i_coord_y,
    input  wire logic [23:0]        i_fill_color,
    input  wire logic [1:0]         i_target_layer,
    output logic [1:0]              o_status,
    output logic                    o_inside_res,
    output logic                    o_write_enable,
    output logic [23:0]             o_write_color,
    output logic [1:0]              o_write_layer
);
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    // quotient magnitude bits: |num| < 2^25, denominator >= 1
    localparam int QW = 25;

    logic [23:0] r_mem [MAX_VERTICES];
    logic [23:0] r_rd;
    logic [CW-1:0] r_count, n_count;
    logic [1:0] r_cmd;
    logic signed [11:0] r_px, r_py;
    logic [AW-1:0] r_idx;
    logic signed [11:0] r_xj, r_yj, r_xi;
    logic r_in;
    logic r_jfix;
    // divider state
    logic [QW-1:0] r_num, r_quo;
    logic [12:0] r_den;
    logic [QW:0] r_rem;
    logic r_neg;
    logic [4:0] r_dcnt;
    logic [1:0] r_status;
    logic r_ins, r_we;

    // vertex memory with registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.append && r_count < CW'(MAX_VERTICES))
            r_mem[r_count[AW-1:0]] <= {r_py, r_px};
        if (i_ctl.rd_first)
            r_rd <= r_mem[AW'(r_count - CW'(1))];
        else if (i_ctl.rd_next)
            r_rd <= r_mem[r_idx];
    end

    // vertex count
    always_comb begin
        n_count = r_count;
        if (i_ctl.clear)
            n_count = '0;
        else if (i_ctl.append && r_count < CW'(MAX_VERTICES))
            n_count = r_count + CW'(1);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_count <= '0;
        else
            r_count <= n_count;
    end

    // edge evaluation terms
    logic signed [11:0] w_xi, w_yi;
    logic w_cross;
    logic signed [12:0] w_dx, w_dy, w_ny;
    logic signed [25:0] w_prod;
    assign w_xi = r_rd[11:0];
    assign w_yi = r_rd[23:12];
    assign w_cross = (w_yi > r_py) != (r_yj > r_py);
    assign w_dx = 13'(r_xj) - 13'(w_xi);
    assign w_dy = 13'(r_yj) - 13'(w_yi);
    assign w_ny = 13'(r_py) - 13'(w_yi);
    assign w_prod = 26'(w_dx) * 26'(w_ny);

    logic [QW:0] w_trial;
    assign w_trial = {r_rem[QW-1:0], r_num[QW-1]} - {13'd0, r_den};

    logic signed [QW+1:0] w_q, w_crs;
    assign w_q = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});
    assign w_crs = w_q + (QW+2)'(r_xi);

    always_ff @(posedge i_clk) begin
        r_jfix <= i_ctl.rd_first;
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_px  <= i_coord_x;
            r_py  <= i_coord_y;
            r_idx <= '0;
            r_in  <= 1'b0;
        end
        // j must hold the last vertex for the first edge
        if (r_jfix) begin
            r_xj <= r_rd[11:0];
            r_yj <= r_rd[23:12];
        end
        if (i_ctl.edge_go) begin
            r_xi  <= w_xi;
            r_num <= QW'(w_prod[25] ? -w_prod : w_prod);
            r_den <= w_dy[12] ? 13'(-w_dy) : 13'(w_dy);
            r_neg <= w_prod[25] ^ w_dy[12];
            r_rem <= '0;
            r_quo <= '0;
            r_dcnt <= '0;
        end
        // restoring division, one quotient bit per step
        if (i_ctl.div_step) begin
            r_num <= {r_num[QW-2:0], 1'b0};
            r_dcnt <= r_dcnt + 5'd1;
            if (!w_trial[QW]) begin
                r_rem <= w_trial;
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[QW-1:0], r_num[QW-1]};
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
        end
        if (i_ctl.div_done && ((QW+2)'(r_px) < w_crs))
            r_in <= ~r_in;
        if (i_ctl.adv) begin
            r_xj  <= w_xi;
            r_yj  <= w_yi;
            r_idx <= r_idx + AW'(1);
        end
    end

    assign o_sts.cmd       = r_cmd;
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.last_edge = (CW'(r_idx) + CW'(1) >= r_count);
    assign o_sts.need_div  = w_cross;
    assign o_sts.div_last  = (r_dcnt == 5'(QW - 1));

    // result register
    logic w_valid, w_on;
    assign w_valid = r_count >= CW'(MIN_POLY_VERTICES);
    assign w_on = (r_px >= 0) && (32'(r_px) < SCREEN_WIDTH) &&
                  (r_py >= 0) && (32'(r_py) < SCREEN_HEIGHT);
    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_status <= ST_OK;
            r_ins <= 1'b0;
            r_we  <= 1'b0;
            case (r_cmd)
                CMD_APPEND: begin
                    if (r_count >= CW'(MAX_VERTICES))
                        r_status <= ST_FULL;
                end
                CMD_TEST: begin
                    r_ins <= r_in;
                    if (!w_valid) r_status <= ST_FEW;
                    r_we <= r_in && w_valid && w_on && (32'(i_target_layer) < LAYERS);
                end
                default: ;
            endcase
        end
    end
    assign o_status      = r_status;
    assign o_inside_res  = r_ins;
    assign o_write_enable = r_we;
    assign o_write_color = i_fill_color;
    assign o_write_layer = i_target_layer;
endmodule
`default_nettype wire

// ===== hw/rtl/pfpt_ctrl.sv =====
`default_nettype none
module pfpt_ctrl
    import pfpt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output logic      o_busy,
    output logic      o_done,
    output t_ctl      o_ctl,
    input  wire t_sts i_sts
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_JRD   = 3'd2;
    localparam logic [2:0] S_IRD   = 3'd3;
    localparam logic [2:0] S_EDGE  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_CMP   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0] r_state, n_state;
    logic r_done;

    always_comb begin
        n_state = r_state;
        o_ctl = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                case (i_sts.cmd)
                    CMD_CLEAR:  begin o_ctl.clear = 1'b1; n_state = S_FIN; end
                    CMD_APPEND: n_state = S_FIN;
                    CMD_TEST: begin
                        if (i_sts.empty) begin
                            n_state = S_FIN;
                        end else begin
                            o_ctl.rd_first = 1'b1;
                            n_state = S_JRD;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_JRD: n_state = S_IRD;
            S_IRD: begin
                o_ctl.rd_next = 1'b1;
                n_state = S_EDGE;
            end
            S_EDGE: begin
                o_ctl.edge_go = 1'b1;
                if (i_sts.need_div) begin
                    n_state = S_DIV;
                end else begin
                    o_ctl.adv = 1'b1;
                    n_state = i_sts.last_edge ? S_FIN : S_IRD;
                end
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_CMP;
            end
            S_CMP: begin
                o_ctl.div_done = 1'b1;
                o_ctl.adv = 1'b1;
                n_state = i_sts.last_edge ? S_FIN : S_IRD;
            end
            S_FIN: begin
                o_ctl.finish = 1'b1;
                o_ctl.append = (i_sts.cmd == CMD_APPEND);
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done <= o_ctl.finish;
        end
    end
    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

`ifndef SYNTHESIS
    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.finish |=> o_done) else $error("done missing");
    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_state == S_IDLE)) else $error("fin stuck");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("start lost");
`endif
endmodule
`default_nettype wire

// ===== sim/polygon_fill_pixel_test_core_tb.sv =====
`timescale 1ns / 100ps
module polygon_fill_pixel_test_core_tb
    import pfpt_pkg::*;
;

    localparam int NUM_VERT    = 16;
    localparam int SCR_W       = 1024;
    localparam int SCR_H       = 1024;
    localparam int NUM_LAYERS  = 4;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [1:0]  status;
        logic        ins;
        logic        we;
        logic [23:0] color;
        logic [1:0]  layer;
    } t_fill_res;

    typedef struct {
        logic [1:0]  cmd;
        int          x;
        int          y;
        int          rep;
        bit          has_exp;
        t_fill_res   exp_res;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_cmd;
    logic signed [11:0] i_coord_x;
    logic signed [11:0] i_coord_y;
    logic              o_done;
    logic [1:0]        o_status;
    logic              o_inside_res;
    logic              o_write_enable;
    logic [23:0]       o_write_color;
    logic [1:0]        o_write_layer;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [0:0]        i_cfg_index;
    logic [23:0]       i_cfg_data;

    // predictor state
    int          vtx_x [NUM_VERT];
    int          vtx_y [NUM_VERT];
    int          vtx_cnt;
    logic [23:0] cur_color;
    logic [1:0]  cur_layer;

    t_fill_res   expected_fills[$];
    int          fail_cnt;
    int          idle_pct;
    int          quiet_cycles;
    bit          item_taken;

    polygon_fill_pixel_test_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_inside_res   (o_inside_res),
        .o_write_enable (o_write_enable),
        .o_write_color  (o_write_color),
        .o_write_layer  (o_write_layer),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // even-odd crossing test over the stored polygon
    function automatic bit crossing_inside(int px, int py);
        bit     in_flag;
        int     j;
        longint xi, yi, xj, yj, x_cross;
        in_flag = 1'b0;
        j = vtx_cnt - 1;
        for (int i = 0; i < vtx_cnt; i++) begin
            xi = vtx_x[i];
            yi = vtx_y[i];
            xj = vtx_x[j];
            yj = vtx_y[j];
            if ((yi > py) != (yj > py)) begin
                x_cross = (xj - xi) * (longint'(py) - yi) / (yj - yi) + xi;
                if (longint'(px) < x_cross)
                    in_flag = !in_flag;
            end
            j = i;
        end
        return in_flag;
    endfunction

    // apply one item to the predictor and return its result
    function automatic t_fill_res fill_predict(logic [1:0] cmd, int px, int py);
        t_fill_res r;
        bit        valid;
        bit        on_scr;
        r = '0;
        r.color = cur_color;
        r.layer = cur_layer;
        case (cmd)
            CMD_CLEAR: begin
                vtx_cnt = 0;
            end
            CMD_APPEND: begin
                if (vtx_cnt >= NUM_VERT) begin
                    r.status = ST_FULL;
                end else begin
                    vtx_x[vtx_cnt] = px;
                    vtx_y[vtx_cnt] = py;
                    vtx_cnt++;
                end
            end
            CMD_TEST: begin
                valid = vtx_cnt >= MIN_POLY_VERTICES;
                on_scr = px >= 0 && px < SCR_W && py >= 0 && py < SCR_H;
                r.ins = crossing_inside(px, py);
                if (!valid)
                    r.status = ST_FEW;
                r.we = r.ins && valid && on_scr && cur_layer < NUM_LAYERS;
            end
            default: ;
        endcase
        return r;
    endfunction

    // send one item, optionally with a typed expectation
    task automatic send_item(logic [1:0] cmd, int px, int py, bit has_exp = 0,
                             t_fill_res exp_res = '0);
        t_fill_res r;
        if ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        start = 1'b1;
        i_cmd = cmd;
        i_coord_x = px[11:0];
        i_coord_y = py[11:0];
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        item_taken = 1'b1;
        r = fill_predict(cmd, px, py);
        expected_fills = {expected_fills, (has_exp ? exp_res : r)};
        @(negedge i_clk);
        item_taken = 1'b0;
        start = 1'b0;
    endtask

    task automatic drain();
        start = 1'b0;
        while (expected_fills.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // register write, only called with the block idle
    task automatic write_reg(logic [0:0] idx, logic [23:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        item_taken = 1'b1;
        if (idx == REG_FILL_COLOR)
            cur_color = data;
        else
            cur_layer = data[1:0];
        @(negedge i_clk);
        item_taken = 1'b0;
        i_cfg_valid = 1'b0;
    endtask

    function automatic int vert_coord();
        if ($urandom_range(9) == 0)
            return int'($urandom_range(0, 4095)) - 2048;
        return int'($urandom_range(0, 1150)) - 60;
    endfunction

    // random polygons with tests, plus some noise items
    task automatic random_phase(int n_items);
        int sent;
        int nv;
        int nt;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) < 8) begin
                send_item(CMD_CLEAR, vert_coord(), vert_coord());
                nv = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 18);
                for (int k = 0; k < nv; k++)
                    send_item(CMD_APPEND, vert_coord(), vert_coord());
                nt = $urandom_range(3, 12);
                for (int k = 0; k < nt; k++)
                    send_item(CMD_TEST, vert_coord(), vert_coord());
                sent += 1 + nv + nt;
            end else begin
                send_item(2'($urandom_range(0, 3)), int'($urandom_range(0, 4095)) - 2048,
                          int'($urandom_range(0, 4095)) - 2048);
                sent++;
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_fill_res got;
        t_fill_res want;
        if (i_rst_n && o_done) begin
            got = '{o_status, o_inside_res, o_write_enable, o_write_color, o_write_layer};
            if (expected_fills.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result %h", got);
            end else begin
                want = expected_fills.pop_front();
                if (got.status !== want.status || got.ins !== want.ins ||
                    got.we !== want.we || got.color !== want.color ||
                    got.layer !== want.layer) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("mismatch: exp st=%0d in=%0d we=%0d col=%h lay=%0d",
                                 want.status, want.ins, want.we, want.color, want.layer);
                        $display("          got st=%0d in=%0d we=%0d col=%h lay=%0d",
                                 got.status, got.ins, got.we, got.color, got.layer);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no progress
    always @(posedge i_clk) begin
        if (item_taken || o_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_dir_row  rows[$];
        t_fill_res ok_r;
        t_fill_res few_r;
        t_fill_res full_r;
        ok_r = '{ST_OK, 1'b0, 1'b0, 24'h0, 2'd0};
        few_r = '{ST_FEW, 1'b0, 1'b0, 24'h0, 2'd0};
        full_r = '{ST_FULL, 1'b0, 1'b0, 24'h0, 2'd0};
        start = 1'b0;
        i_cmd = CMD_CLEAR;
        i_coord_x = '0;
        i_coord_y = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_FILL_COLOR;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        vtx_cnt = 0;
        cur_color = '0;
        cur_layer = '0;
        fail_cnt = 0;
        quiet_cycles = 0;
        item_taken = 1'b0;
        idle_pct = 15;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed items, reset configuration
        rows = '{
            '{CMD_CLEAR,      0,     0,  1, 1, ok_r},
            '{CMD_TEST,       0,     0,  1, 1, few_r},
            '{CMD_APPEND, -2048, -2048,  1, 1, ok_r},
            '{CMD_TEST,    2047,  2047,  1, 0, ok_r},
            '{CMD_APPEND,  2047, -2048,  1, 1, ok_r},
            '{CMD_APPEND,     0,  2047,  1, 1, ok_r},
            '{CMD_TEST,       0,     0,  1, 0, ok_r},
            '{CMD_TEST,   -2048,  2047,  1, 0, ok_r},
            '{CMD_TEST,    2047,     0,  1, 0, ok_r},
            '{CMD_TEST,    1023,  1023,  1, 0, ok_r},
            '{CMD_TEST,    1024,     5,  1, 0, ok_r},
            '{CMD_TEST,      -1,     3,  1, 0, ok_r},
            '{CMD_APPEND,   512,   512, 13, 1, ok_r},
            '{CMD_APPEND,     1,     1,  1, 1, full_r},
            '{CMD_TEST,     100,     0,  1, 0, ok_r},
            '{2'd3,          -1,    -1,  1, 1, ok_r},
            '{CMD_CLEAR,      0,     0,  1, 1, ok_r},
            '{CMD_APPEND,    10,    10,  1, 1, ok_r},
            '{CMD_APPEND,  1000,    10,  1, 1, ok_r},
            '{CMD_APPEND,   500,  1000,  1, 1, ok_r},
            '{CMD_TEST,     500,   100,  1, 0, ok_r},
            '{CMD_TEST,     500,  1000,  1, 0, ok_r},
            '{CMD_TEST,      10,    10,  1, 0, ok_r},
            '{CMD_TEST,     990,    11,  1, 0, ok_r}
        };
        foreach (rows[r])
            for (int k = 0; k < rows[r].rep; k++)
                send_item(rows[r].cmd, rows[r].x, rows[r].y,
                          rows[r].has_exp, rows[r].exp_res);
        drain();

        // phase one: extremes high, light sender idling
        write_reg(REG_FILL_COLOR, 24'hFFFFFF);
        write_reg(REG_TARGET_LAYER, 24'd3);
        random_phase(630);
        drain();

        // phase two: extremes low, heavy sender idling
        idle_pct = 88;
        write_reg(REG_FILL_COLOR, 24'h000000);
        write_reg(REG_TARGET_LAYER, 24'd0);
        random_phase(630);
        drain();

        // phase three: random setting, back to back
        idle_pct = 0;
        write_reg(REG_FILL_COLOR, 24'($urandom));
        write_reg(REG_TARGET_LAYER, 24'($urandom_range(0, 3)));
        random_phase(630);
        drain();

        if (fail_cnt == 0 && expected_fills.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/pfpt_pkg.sv
hw/rtl/pfpt_datapath.sv
hw/rtl/pfpt_ctrl.sv
hw/rtl/polygon_fill_pixel_test_core.sv
sim/polygon_fill_pixel_test_core_tb.sv
